/* rtl/core/rpa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    typedef logic [2:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_ALLOC   = 3'd0;
    localparam t_op OP_FREE    = 3'd1;
    localparam t_op OP_ADDREF  = 3'd2;
    localparam t_op OP_DROPREF = 3'd3;
    localparam t_op OP_READ    = 3'd4;
    localparam t_op OP_SEED    = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_OOM   = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_LIMIT = 2'd3;

    localparam logic [1:0] CFG_FIRST_PAGE = 2'd0;
    localparam logic [1:0] CFG_TOP_PAGE   = 2'd1;

    localparam logic [16:0] TOP_PAGE_RESET = 17'd57344;
    localparam logic [16:0] TOTAL_MAX      = 17'h1FFFF;

    // Classified transaction handed from front to back.
    typedef struct packed {
        t_op         op;
        logic [15:0] page;
        logic        undef_op;
        logic        out_of_range;
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/core/refcounted_page_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// LIFO free-list page allocator with a saturating reference count per page.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_op, i_page
//  result    out        o_valid / i_ready   o_status, o_alloc_page,
//                                           o_ref_count, o_free_pages
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
//  Back end: fetch reads the count and link memories, execute updates them
//  and the list head; no new fetch until the previous transaction executes.
//  After reset the count memory is swept to zero, one entry a cycle, over all
//  min(NUM_PAGES, 65536) entries; o_ready stays low during the sweep.
//  A stalled result holds the back end; the two-entry queue still fills.
// ----------------------------------------------------------------------------
module refcounted_page_allocator #(
    parameter int NUM_PAGES  = 65536,
    parameter int COUNT_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [16:0]       i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire rpa_pkg::t_op      i_op,
    input  wire logic [15:0]       i_page,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rpa_pkg::t_status       o_status,
    output logic [15:0]            o_alloc_page,
    output logic [7:0]             o_ref_count,
    output logic [16:0]            o_free_pages
);
    import rpa_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic clearing;

    assign o_ready = !queue_full && !clearing;

    rpa_front #(
        .NUM_PAGES (NUM_PAGES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_page      (i_page),
        .o_cmd       (front_cmd)
    );

    rpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && o_ready),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    rpa_back #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (queue_valid),
        .i_cmd        (queue_cmd),
        .o_cmd_pop    (queue_pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_alloc_page (o_alloc_page),
        .o_ref_count  (o_ref_count),
        .o_free_pages (o_free_pages)
    );

endmodule
`default_nettype wire

/* rtl/core/rpa_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_front
// Range registers and classification of incoming transactions.
// ----------------------------------------------------------------------------
module rpa_front #(
    parameter int NUM_PAGES = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [16:0]      i_cfg_data,
    input  wire rpa_pkg::t_op     i_op,
    input  wire logic [15:0]      i_page,
    output rpa_pkg::t_cmd         o_cmd
);
    import rpa_pkg::*;

    localparam logic [20:0] NUM_PAGES_W = 21'(NUM_PAGES);

    logic [15:0] r_first_page;
    logic [16:0] r_top_page;
    logic        page_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
            r_top_page   <= TOP_PAGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_PAGE: r_first_page <= i_cfg_data[15:0];
                CFG_TOP_PAGE:   r_top_page   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign page_ok = (i_page >= r_first_page) && ({1'b0, i_page} < r_top_page)
                   && ({5'b0, i_page} < NUM_PAGES_W);

    always_comb begin
        o_cmd.op           = i_op;
        o_cmd.page         = i_page;
        o_cmd.undef_op     = (i_op > OP_SEED);
        // alloc ignores the page, so it is never rejected
        o_cmd.out_of_range = (i_op != OP_ALLOC) && (i_op <= OP_SEED) && !page_ok;
    end

endmodule
`default_nettype wire

/* rtl/core/rpa_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module rpa_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rpa_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output rpa_pkg::t_cmd      o_cmd
);
    import rpa_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/rpa_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_back
// Free list, reference counts and result register; fetch then execute.
// ----------------------------------------------------------------------------
module rpa_back #(
    parameter int NUM_PAGES  = 65536,
    parameter int COUNT_BITS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire rpa_pkg::t_cmd    i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_clearing,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output rpa_pkg::t_status      o_status,
    output logic [15:0]           o_alloc_page,
    output logic [7:0]            o_ref_count,
    output logic [16:0]           o_free_pages
);
    import rpa_pkg::*;

    localparam int MEM_DEPTH = (NUM_PAGES < 65536) ? NUM_PAGES : 65536;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(MEM_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    logic [COUNT_BITS-1:0] mem_refs [MEM_DEPTH];
    logic [15:0]           mem_link [MEM_DEPTH];

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_clr_idx;
    t_cmd                  r_cmd;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [15:0]           r_link_rd;
    logic [15:0]           r_list_head, n_list_head;
    logic                  r_nonempty, n_nonempty;
    logic [16:0]           r_free_total, n_free_total;
    logic                  r_out_valid;

    logic                  fetch_fire;
    logic                  exec_fire;
    logic                  push;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [COUNT_BITS-1:0] res_cnt;
    logic [15:0]           res_cnt_wide;
    t_status               res_status;
    logic [15:0]           res_given;
    logic                  refs_we;
    logic [IDX_W-1:0]      refs_addr;
    logic [COUNT_BITS-1:0] refs_data;
    logic [16:0]           total_dec;

    assign fetch_fire = (r_state == S_FETCH) && i_cmd_valid;
    assign exec_fire  = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    assign o_cmd_pop  = fetch_fire;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_valid;
    assign total_dec  = (r_free_total != 17'd0) ? r_free_total - 17'd1 : r_free_total;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_idx == LAST_IDX) n_state = S_FETCH;
            S_FETCH: if (i_cmd_valid) n_state = S_EXEC;
            S_EXEC:  if (exec_fire) n_state = S_FETCH;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_list_head  = r_list_head;
        n_nonempty   = r_nonempty;
        n_free_total = r_free_total;
        push         = 1'b0;
        new_cnt      = r_cnt_rd;
        res_status   = ST_OK;
        res_given    = '0;
        res_cnt      = '0;
        refs_we      = 1'b0;
        refs_addr    = r_cmd.page[IDX_W-1:0];
        refs_data    = new_cnt;

        if (r_cmd.undef_op) begin
            res_status = ST_OK;
        end else if (r_cmd.op == OP_ALLOC) begin
            if (!r_nonempty) begin
                res_status = ST_OOM;
            end else begin
                n_list_head  = r_link_rd;
                n_free_total = total_dec;
                n_nonempty   = (total_dec != 17'd0);
                refs_we      = 1'b1;
                refs_addr    = r_list_head[IDX_W-1:0];
                refs_data    = COUNT_BITS'(1);
                res_given    = r_list_head;
                res_cnt      = COUNT_BITS'(1);
            end
        end else if (r_cmd.out_of_range) begin
            res_status = ST_RANGE;
        end else begin
            case (r_cmd.op)
                OP_FREE: begin
                    if (r_cnt_rd != '0) begin
                        new_cnt = r_cnt_rd - COUNT_BITS'(1);
                    end
                    push = (new_cnt == '0);
                end
                OP_ADDREF: begin
                    if (r_cnt_rd == COUNT_MAX) begin
                        res_status = ST_LIMIT;
                    end else begin
                        new_cnt = r_cnt_rd + COUNT_BITS'(1);
                    end
                end
                OP_DROPREF: begin
                    if (r_cnt_rd == '0) begin
                        res_status = ST_LIMIT;
                    end else begin
                        new_cnt = r_cnt_rd - COUNT_BITS'(1);
                    end
                end
                OP_SEED: begin
                    new_cnt = '0;
                    push    = 1'b1;
                end
                default: ;
            endcase
            refs_we   = 1'b1;
            refs_data = new_cnt;
            res_cnt   = new_cnt;
        end

        if (push) begin
            n_list_head  = r_cmd.page;
            n_nonempty   = 1'b1;
            n_free_total = (r_free_total == TOTAL_MAX) ? r_free_total
                                                       : r_free_total + 17'd1;
        end

        // the sweep after reset owns the count memory
        if (r_state == S_CLEAR) begin
            refs_we   = 1'b1;
            refs_addr = r_clr_idx;
            refs_data = '0;
        end else if (!exec_fire) begin
            refs_we = 1'b0;
        end
    end

    assign res_cnt_wide = 16'(res_cnt);

    always_ff @(posedge i_clk) begin
        if (refs_we) begin
            mem_refs[refs_addr] <= refs_data;
        end
        if (exec_fire && push) begin
            mem_link[r_cmd.page[IDX_W-1:0]] <= r_list_head;
        end
        if (fetch_fire) begin
            r_cnt_rd  <= mem_refs[i_cmd.page[IDX_W-1:0]];
            r_link_rd <= mem_link[r_list_head[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch_fire) begin
            r_cmd <= i_cmd;
        end
        if (exec_fire) begin
            o_status     <= res_status;
            o_alloc_page <= res_given;
            o_ref_count  <= res_cnt_wide[7:0];
            o_free_pages <= n_free_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_list_head  <= '0;
            r_nonempty   <= 1'b0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (exec_fire) begin
                r_list_head  <= n_list_head;
                r_nonempty   <= n_nonempty;
                r_free_total <= n_free_total;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reference-counted page allocator.
// Requests go in over valid/ready with random bursts and gaps. Results come
// back under a rotating ready stall pattern. Each accepted request is run
// through a local model of the free list and the count table. The expected
// result is queued and compared field by field with the next result.
// ----------------------------------------------------------------------------
module tb;
    import rpa_pkg::*;

    localparam t_op OP_UNDEF_6 = 3'd6;
    localparam t_op OP_UNDEF_7 = 3'd7;

    localparam logic [7:0] COUNT_LIMIT = 8'hFF;

    localparam int unsigned MIX_GENERAL = 0;
    localparam int unsigned MIX_CLIMB   = 1;
    localparam int unsigned MIX_DESCEND = 2;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        t_status     status;
        logic [15:0] alloc_page;
        logic [7:0]  ref_count;
        logic [16:0] free_pages;
    } t_reply;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_FIRST_PAGE;
    logic [16:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    t_op         i_op        = OP_ALLOC;
    logic [15:0] i_page      = '0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    t_status     o_status;
    logic [15:0] o_alloc_page;
    logic [7:0]  o_ref_count;
    logic [16:0] o_free_pages;

    // Local copy of the allocator state and range registers.
    logic [15:0] free_link [0:65535];
    logic [7:0]  page_count [0:65535];
    logic [15:0] free_head     = '0;
    logic        free_nonempty = 1'b0;
    logic [16:0] free_count    = '0;
    logic [15:0] win_first     = '0;
    logic [16:0] win_top       = TOP_PAGE_RESET;

    t_reply expected_replies [$];
    t_reply want;
    int     error_count = 0;
    int     idle_cycles = 0;
    int     burst_left  = 0;
    bit     sender_gappy = 1'b1;
    logic [15:0] rx_pattern = 16'hFFFF;
    logic [5:0]  rx_tick    = '0;

    refcounted_page_allocator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_page       (i_page),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_alloc_page (o_alloc_page),
        .o_ref_count  (o_ref_count),
        .o_free_pages (o_free_pages)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void push_free_page(logic [15:0] page);
        free_link[page] = free_head;
        free_head = page;
        free_nonempty = 1'b1;
        if (free_count != TOTAL_MAX) free_count = free_count + 17'd1;
    endfunction

    function automatic t_reply predict_page_op(t_op op, logic [15:0] page);
        t_reply r;
        logic [7:0]  cnt;
        logic [15:0] head;
        r = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (!free_nonempty) begin
                r.status = ST_OOM;
            end else begin
                head = free_head;
                free_head = free_link[head];
                page_count[head] = 8'd1;
                if (free_count != 0) free_count = free_count - 17'd1;
                if (free_count == 0) free_nonempty = 1'b0;
                r.alloc_page = head;
                r.ref_count = 8'd1;
            end
        end else if (op <= OP_SEED) begin
            if (page < win_first || {1'b0, page} >= win_top) begin
                r.status = ST_RANGE;
            end else begin
                cnt = page_count[page];
                case (op)
                    OP_FREE: begin
                        if (cnt != 0) cnt = cnt - 8'd1;
                        if (cnt == 0) push_free_page(page);
                    end
                    OP_ADDREF: begin
                        if (cnt == COUNT_LIMIT) r.status = ST_LIMIT;
                        else cnt = cnt + 8'd1;
                    end
                    OP_DROPREF: begin
                        if (cnt == 0) r.status = ST_LIMIT;
                        else cnt = cnt - 8'd1;
                    end
                    OP_SEED: begin
                        cnt = 8'd0;
                        push_free_page(page);
                    end
                    default: ;
                endcase
                page_count[page] = cnt;
                r.ref_count = cnt;
            end
        end
        r.free_pages = free_count;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= MAX_PRINTED) $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // Drive one request and wait for its transaction; valid stays up afterwards.
    task automatic send_request(t_op op, logic [15:0] page);
        int gap;
        if (sender_gappy && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_valid <= 1'b1;
        i_op    <= op;
        i_page  <= page;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_replies.push_back(predict_page_op(op, page));
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_range(logic [15:0] first_pg, logic [16:0] top_pg);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FIRST_PAGE;
        i_cfg_data  <= {1'b0, first_pg};
        @(posedge i_clk);
        i_cfg_index <= CFG_TOP_PAGE;
        i_cfg_data  <= top_pg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_first = first_pg;
        win_top   = top_pg;
    endtask

    function automatic t_op pick_op(int unsigned mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (mix == MIX_CLIMB) return roll < 90 ? OP_ADDREF : (roll < 95 ? OP_READ : OP_DROPREF);
        if (mix == MIX_DESCEND) return roll < 90 ? OP_DROPREF : (roll < 95 ? OP_READ : OP_ADDREF);
        if (roll < 22) return OP_ALLOC;
        if (roll < 40) return OP_FREE;
        if (roll < 55) return OP_ADDREF;
        if (roll < 68) return OP_DROPREF;
        if (roll < 78) return OP_READ;
        if (roll < 94) return OP_SEED;
        return $urandom_range(0, 1) ? OP_UNDEF_7 : OP_UNDEF_6;
    endfunction

    // Mostly pages inside the window, some at its boundaries, some anywhere.
    function automatic logic [15:0] pick_page();
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        span = (win_top > {1'b0, win_first}) ? int'(win_top) - int'(win_first) : 0;
        if (roll < 8 || span == 0) return 16'($urandom);
        if (roll < 12) return 16'(win_first - 16'd1);
        if (roll < 16) return 16'(win_top);
        return 16'(int'(win_first) + $urandom_range(0, span - 1));
    endfunction

    task automatic test_directed_cases();
        sender_gappy = 1'b1;
        send_request(OP_ALLOC, 16'd0);
        send_request(OP_READ, 16'd0);
        send_request(OP_SEED, 16'hFFFF);
        send_request(OP_SEED, 16'd57344);
        send_request(OP_SEED, 16'd57343);
        send_request(OP_SEED, 16'd0);
        send_request(OP_ALLOC, 16'hFFFF);
        send_request(OP_ALLOC, 16'd0);
        send_request(OP_ALLOC, 16'd0);
        send_request(OP_FREE, 16'd0);
        // count already zero: pushed a second time
        send_request(OP_FREE, 16'd0);
        send_request(OP_DROPREF, 16'd57343);
        send_request(OP_DROPREF, 16'd57343);
        send_request(OP_ADDREF, 16'd0);
        send_request(OP_READ, 16'd0);
        send_request(OP_UNDEF_6, 16'd0);
        send_request(OP_UNDEF_7, 16'hFFFF);
        send_request(OP_ALLOC, 16'd0);
        send_request(OP_ALLOC, 16'd0);
        set_range(16'd10, 17'd20);
        send_request(OP_SEED, 16'd9);
        send_request(OP_SEED, 16'd20);
        send_request(OP_SEED, 16'd12);
        send_request(OP_ADDREF, 16'd19);
        // page 12 is now outside the window but still sits at the head
        set_range(16'd30, 17'd40);
        send_request(OP_ALLOC, 16'd0);
        send_request(OP_FREE, 16'd12);
    endtask

    task automatic test_range_extremes();
        set_range(16'd0, 17'h10000);
        send_request(OP_SEED, 16'hFFFF);
        send_request(OP_SEED, 16'd0);
        send_request(OP_READ, 16'hFFFF);
        send_request(OP_ALLOC, 16'd0);
        send_request(OP_ALLOC, 16'd0);
        set_range(16'hFFFF, 17'h10000);
        send_request(OP_SEED, 16'hFFFE);
        send_request(OP_SEED, 16'hFFFF);
        send_request(OP_FREE, 16'hFFFF);
        send_request(OP_ALLOC, 16'd0);
        set_range(16'hFFFF, 17'd1);
        send_request(OP_READ, 16'hFFFF);
        send_request(OP_READ, 16'd0);
        send_request(OP_ALLOC, 16'd0);
        set_range(16'd0, 17'd1);
        send_request(OP_READ, 16'd0);
        send_request(OP_READ, 16'd1);
        set_range(16'd0, 17'h0FFFF);
        send_request(OP_SEED, 16'hFFFF);
        send_request(OP_SEED, 16'hFFFE);
    endtask

    // Walk one page up to the count ceiling and back down past zero.
    task automatic test_count_limits();
        set_range(16'd300, 17'd301);
        sender_gappy = 1'b0;
        send_request(OP_SEED, 16'd300);
        send_request(OP_ALLOC, 16'd0);
        repeat (380) send_request(pick_op(MIX_CLIMB), pick_page());
        sender_gappy = 1'b1;
        repeat (380) send_request(pick_op(MIX_DESCEND), pick_page());
    endtask

    task automatic test_random_windows();
        int unsigned span;
        int unsigned base;
        for (int ph = 0; ph < 9; ph++) begin
            span = 1 << $urandom_range(0, 5);
            case ($urandom_range(0, 3))
                0: base = 0;
                1: base = 65536 - span;
                default: base = $urandom_range(0, 65536 - span);
            endcase
            set_range(16'(base), 17'(base + span));
            sender_gappy = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 100; n++) begin
                if (ph == 4 && n == 50) begin
                    wait_results_drained();
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end
                send_request(pick_op(MIX_GENERAL), pick_page());
            end
        end
    endtask

    // Receiver: rotate a stall pattern, refreshed each time the 6-bit tick wraps.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == 0) begin
            rx_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end else begin
            rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
        end
        i_ready <= rx_pattern[0];
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        o_status, want.status));
                if (o_alloc_page !== want.alloc_page)
                    report_mismatch($sformatf("alloc_page %0d, expected %0d",
                        o_alloc_page, want.alloc_page));
                if (o_ref_count !== want.ref_count)
                    report_mismatch($sformatf("ref_count %0d, expected %0d",
                        o_ref_count, want.ref_count));
                if (o_free_pages !== want.free_pages)
                    report_mismatch($sformatf("free_pages %0d, expected %0d",
                        o_free_pages, want.free_pages));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        for (int p = 0; p < 65536; p++) begin
            page_count[16'(p)] = '0;
            free_link[16'(p)]  = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_range_extremes();
        test_count_limits();
        test_random_windows();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
